// ===== hdl/dkstl_pkg.sv =====
// package for the dual-key sorted table lookup core
// function and status codes, field widths and default table size; no dependencies
`default_nettype none

package dkstl_pkg;

    localparam int MAX_RECORDS_DEF = 256;

    localparam int FUNC_W   = 2;
    localparam int STOCK_W  = 32;
    localparam int PRICE_W  = 32;
    localparam int PART_W   = 64;
    localparam int STATUS_W = 2;
    localparam int KEY_W    = 32;
    localparam int REC_W    = STOCK_W + PRICE_W + PART_W;

    localparam int IN_DATA_W  = STOCK_W + PRICE_W + PART_W;
    localparam int OUT_DATA_W = PART_W + STOCK_W;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD       = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIND_STOCK = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_FIND_PRICE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    // flipping the sign bit maps signed order onto unsigned order
    localparam logic [KEY_W-1:0] SIGN_FLIP = 32'h8000_0000;

endpackage

`default_nettype wire

// ===== hdl/dkstl_ram.sv =====
// simple dual-port memory: one write port, one read port with registered data
// no package dependency
`default_nettype none

module dkstl_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/dkstl_step.sv =====
// shared binary search step: midpoint, key compare and bound update
// uses dkstl_pkg for the key width
`default_nettype none

module dkstl_step #(
    parameter int CNT_W = 9
) (
    input  wire logic [CNT_W-1:0]           lo,
    input  wire logic [CNT_W-1:0]           hi,
    input  wire logic [dkstl_pkg::KEY_W-1:0] key_v,
    input  wire logic [dkstl_pkg::KEY_W-1:0] key_k,
    input  wire logic                       upper,
    output logic      [CNT_W-1:0]           mid,
    output logic      [CNT_W-1:0]           lo_next,
    output logic      [CNT_W-1:0]           hi_next,
    output logic                            eq
);

    import dkstl_pkg::*;

    logic [CNT_W-1:0] span;
    logic             go_right;

    always_comb
    begin
        span     = hi - lo;
        mid      = lo + (span >> 1);
        eq       = (key_v == key_k);
        // upper bound steps past equal keys, lower bound stops on them
        go_right = upper ? (key_v <= key_k) : (key_v < key_k);
        lo_next  = go_right ? CNT_W'(mid + 1'b1) : lo;
        hi_next  = go_right ? hi : mid;
    end

endmodule

`default_nettype wire

// ===== hdl/dual_key_sorted_table_lookup_core.sv =====
// lookup: each search step reads the order RAM, then the record RAM, then compares keys
// load: two sorted inserts, stock order then price order, each a search for the upper
//   bound followed by a shift of the tail up by one before the new index is written
// clear, full and empty: no search; one item at a time, result held in an output register
// reset: asynchronous active low, empties the table; memories are not cleared
`default_nettype none

module dual_key_sorted_table_lookup_core #(
    parameter int MAX_RECORDS = dkstl_pkg::MAX_RECORDS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // stock_number [31:0], price_cents [63:32], part_number [127:64]
    input  wire logic [dkstl_pkg::IN_DATA_W-1:0]  s_tdata,
    // func [1:0]
    input  wire logic [dkstl_pkg::FUNC_W-1:0]     s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // found_part_number [63:0], found_stock_number [95:64]
    output logic      [dkstl_pkg::OUT_DATA_W-1:0] m_tdata,
    // status [1:0]
    output logic      [dkstl_pkg::STATUS_W-1:0]   m_tuser
);

    import dkstl_pkg::*;

    localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CNT_W = $clog2(MAX_RECORDS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRD_ORD,
        S_SRD_REC,
        S_SCMP,
        S_SHIFT,
        S_FRD_REC,
        S_FCHK,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [CNT_W-1:0]    sh_ptr_reg, sh_ptr_next;
    logic [IDX_W-1:0]    wr_addr_reg, wr_addr_next;
    logic                rd_pend_reg, rd_pend_next;
    logic                sel_reg, sel_next;      // 0 stock order, 1 price order
    logic                upper_reg, upper_next;  // load searches for the upper bound
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [PRICE_W-1:0]  price_reg, price_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [PART_W-1:0]   res_part_reg, res_part_next;
    logic [STOCK_W-1:0]  res_stock_reg, res_stock_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0] m_tuser_reg, m_tuser_next;

    logic [STOCK_W-1:0] in_stock;
    logic [PRICE_W-1:0] in_price;
    logic [PART_W-1:0]  in_part;
    logic               accept;
    logic               full;

    logic               rec_we;
    logic [IDX_W-1:0]   rec_waddr;
    logic [REC_W-1:0]   rec_wdata;
    logic [REC_W-1:0]   rec_rdata;
    logic [STOCK_W-1:0] rec_stock;
    logic [PRICE_W-1:0] rec_price;
    logic [PART_W-1:0]  rec_part;
    logic [KEY_W-1:0]   rec_key;

    logic               ord_we;
    logic [IDX_W-1:0]   ord_waddr;
    logic [IDX_W-1:0]   ord_wdata;
    logic [IDX_W-1:0]   ord_raddr;
    logic [IDX_W-1:0]   ord_s_rdata;
    logic [IDX_W-1:0]   ord_p_rdata;
    logic [IDX_W-1:0]   ord_rdata;

    logic [CNT_W-1:0]   mid;
    logic [CNT_W-1:0]   step_lo;
    logic [CNT_W-1:0]   step_hi;
    logic               key_eq;
    logic [CNT_W-1:0]   sh_dec;

    assign in_stock  = s_tdata[STOCK_W-1:0];
    assign in_price  = s_tdata[STOCK_W+PRICE_W-1:STOCK_W];
    assign in_part   = s_tdata[IN_DATA_W-1:STOCK_W+PRICE_W];
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign full      = (count_reg == CNT_W'(MAX_RECORDS));

    assign rec_we    = accept && (s_tuser == FUNC_LOAD) && !full;
    assign rec_waddr = count_reg[IDX_W-1:0];
    assign rec_wdata = {in_part, in_price, in_stock};
    assign rec_stock = rec_rdata[STOCK_W-1:0];
    assign rec_price = rec_rdata[STOCK_W+PRICE_W-1:STOCK_W];
    assign rec_part  = rec_rdata[REC_W-1:STOCK_W+PRICE_W];
    assign rec_key   = sel_reg ? rec_price : (rec_stock ^ SIGN_FLIP);
    assign ord_rdata = sel_reg ? ord_p_rdata : ord_s_rdata;
    assign sh_dec    = sh_ptr_reg - 1'b1;

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    dkstl_ram #(
        .WIDTH  (REC_W),
        .DEPTH  (MAX_RECORDS),
        .ADDR_W (IDX_W)
    ) u_rec_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata (rec_wdata),
        .raddr (ord_rdata),
        .rdata (rec_rdata)
    );

    dkstl_ram #(
        .WIDTH  (IDX_W),
        .DEPTH  (MAX_RECORDS),
        .ADDR_W (IDX_W)
    ) u_ord_stock_ram (
        .clk   (clk),
        .we    (ord_we && !sel_reg),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_s_rdata)
    );

    dkstl_ram #(
        .WIDTH  (IDX_W),
        .DEPTH  (MAX_RECORDS),
        .ADDR_W (IDX_W)
    ) u_ord_price_ram (
        .clk   (clk),
        .we    (ord_we && sel_reg),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_p_rdata)
    );

    dkstl_step #(
        .CNT_W (CNT_W)
    ) u_step (
        .lo      (lo_reg),
        .hi      (hi_reg),
        .key_v   (rec_key),
        .key_k   (key_reg),
        .upper   (upper_reg),
        .mid     (mid),
        .lo_next (step_lo),
        .hi_next (step_hi),
        .eq      (key_eq)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        sh_ptr_next     = sh_ptr_reg;
        wr_addr_next    = wr_addr_reg;
        rd_pend_next    = rd_pend_reg;
        sel_next        = sel_reg;
        upper_next      = upper_reg;
        key_next        = key_reg;
        price_next      = price_reg;
        res_status_next = res_status_reg;
        res_part_next   = res_part_reg;
        res_stock_next  = res_stock_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        ord_we    = 1'b0;
        ord_waddr = wr_addr_reg;
        ord_wdata = ord_rdata;
        ord_raddr = mid[IDX_W-1:0];

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = ST_OK;
                    res_part_next   = '0;
                    res_stock_next  = '0;
                    lo_next         = '0;
                    hi_next         = count_reg;
                    price_next      = in_price;
                    unique case (s_tuser) inside
                        FUNC_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_OUT;
                        end
                        FUNC_LOAD:
                        begin
                            if (full)
                            begin
                                res_status_next = ST_FULL;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                sel_next   = 1'b0;
                                upper_next = 1'b1;
                                key_next   = in_stock ^ SIGN_FLIP;
                                state_next = S_SRD_ORD;
                            end
                        end
                        FUNC_FIND_STOCK, FUNC_FIND_PRICE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                sel_next   = (s_tuser == FUNC_FIND_PRICE);
                                upper_next = 1'b0;
                                key_next   = (s_tuser == FUNC_FIND_PRICE) ? in_price
                                                                           : (in_stock ^ SIGN_FLIP);
                                state_next = S_SRD_ORD;
                            end
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            S_SRD_ORD:
            begin
                if (lo_reg != hi_reg)
                begin
                    ord_raddr  = mid[IDX_W-1:0];
                    state_next = S_SRD_REC;
                end
                else if (upper_reg)
                begin
                    // insert position found, shift the tail up by one
                    sh_ptr_next  = count_reg;
                    rd_pend_next = 1'b0;
                    state_next   = S_SHIFT;
                end
                else if (lo_reg == count_reg)
                begin
                    res_status_next = ST_MISS;
                    state_next      = S_OUT;
                end
                else
                begin
                    ord_raddr  = lo_reg[IDX_W-1:0];
                    state_next = S_FRD_REC;
                end
            end

            S_SRD_REC:
            begin
                state_next = S_SCMP;
            end

            S_SCMP:
            begin
                lo_next    = step_lo;
                hi_next    = step_hi;
                state_next = S_SRD_ORD;
            end

            S_SHIFT:
            begin
                ord_raddr = sh_dec[IDX_W-1:0];
                if (rd_pend_reg)
                begin
                    ord_we    = 1'b1;
                    ord_waddr = wr_addr_reg;
                    ord_wdata = ord_rdata;
                end
                if (sh_ptr_reg > lo_reg)
                begin
                    rd_pend_next = 1'b1;
                    wr_addr_next = sh_ptr_reg[IDX_W-1:0];
                    sh_ptr_next  = sh_dec;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                    if (!rd_pend_reg)
                    begin
                        ord_we    = 1'b1;
                        ord_waddr = lo_reg[IDX_W-1:0];
                        ord_wdata = count_reg[IDX_W-1:0];
                        if (!sel_reg)
                        begin
                            sel_next   = 1'b1;
                            key_next   = price_reg;
                            lo_next    = '0;
                            hi_next    = count_reg;
                            state_next = S_SRD_ORD;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                            state_next = S_OUT;
                        end
                    end
                end
            end

            S_FRD_REC:
            begin
                state_next = S_FCHK;
            end

            S_FCHK:
            begin
                if (key_eq)
                begin
                    if (sel_reg)
                    begin
                        res_stock_next = rec_stock;
                    end
                    else
                    begin
                        res_part_next = rec_part;
                    end
                end
                else
                begin
                    res_status_next = ST_MISS;
                end
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_stock_reg, res_part_reg};
                    m_tuser_next  = res_status_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            sh_ptr_reg     <= '0;
            wr_addr_reg    <= '0;
            rd_pend_reg    <= 1'b0;
            sel_reg        <= 1'b0;
            upper_reg      <= 1'b0;
            key_reg        <= '0;
            price_reg      <= '0;
            res_status_reg <= ST_OK;
            res_part_reg   <= '0;
            res_stock_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tuser_reg    <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            sh_ptr_reg     <= sh_ptr_next;
            wr_addr_reg    <= wr_addr_next;
            rd_pend_reg    <= rd_pend_next;
            sel_reg        <= sel_next;
            upper_reg      <= upper_next;
            key_reg        <= key_next;
            price_reg      <= price_next;
            res_status_reg <= res_status_next;
            res_part_reg   <= res_part_next;
            res_stock_reg  <= res_stock_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_tdata_reg    <= m_tdata_next;
            m_tuser_reg    <= m_tuser_next;
        end
    end

endmodule

`default_nettype wire
